@@ rtl/rie_pkg.sv @@
// shared types and constants of the integer to roman numeral encoder
package rie_pkg;

  localparam int VALUE_W = 12;
  localparam int SYM_W = 7;
  localparam int TABLE_LEN = 13;
  localparam int IDX_W = 4;

  localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [IDX_W-1:0] idx_t;

  // ascii codes of the numeral letters
  localparam sym_t NO_CH = 7'd0;
  localparam sym_t CH_I = 7'h49;
  localparam sym_t CH_V = 7'h56;
  localparam sym_t CH_X = 7'h58;
  localparam sym_t CH_L = 7'h4C;
  localparam sym_t CH_C = 7'h43;
  localparam sym_t CH_D = 7'h44;
  localparam sym_t CH_M = 7'h4D;

  // greedy table, largest weight first
  localparam value_t WEIGHT [TABLE_LEN] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam sym_t FIRST_CH [TABLE_LEN] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  // second letter of a subtractive pair, none for single letters
  localparam sym_t SECOND_CH [TABLE_LEN] = '{
    NO_CH, CH_M, NO_CH, CH_D, NO_CH, CH_C, NO_CH, CH_L, NO_CH, CH_X, NO_CH,
    CH_V, NO_CH
  };

  // one classified item waiting for the back end
  typedef struct packed {
    logic   bad;
    value_t value;
  } entry_t;

endpackage

@@ rtl/rie_front.sv @@
// front end: accepts items, range checks them and queues them for the back end
module rie_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  rie_pkg::value_t in_value,
  output logic            q_valid,
  output rie_pkg::entry_t q_entry,
  input  logic            q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rie_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  rie_pkg::entry_t  new_entry;

  // zero and anything past the largest numeral are flagged
  always_comb begin
    new_entry.value = in_value;
    new_entry.bad   = (in_value == '0) || (in_value > rie_pkg::MAX_VALID);
  end

  assign busy    = (count_r == CNT_W'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

@@ rtl/rie_back.sv @@
// back end: greedy subtraction engine, one numeral letter per cycle
module rie_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  rie_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            out_strobe,
  output rie_pkg::sym_t   out_symbol,
  output logic            out_last,
  output logic            out_bad_value
);

  logic            active_r, active_nxt;
  logic            bad_r, bad_nxt;
  rie_pkg::value_t rest_r, rest_nxt;
  logic            pend_r, pend_nxt;
  rie_pkg::sym_t   pend_sym_r, pend_sym_nxt;

  logic            strobe_r;
  rie_pkg::sym_t   symbol_r;
  logic            last_r;
  logic            bad_out_r;

  rie_pkg::idx_t   sel;
  logic            found;
  logic            emit;
  rie_pkg::sym_t   emit_sym;
  logic            emit_last;
  logic            emit_bad;
  logic            load;

  // largest weight not above the remainder
  always_comb begin
    sel   = rie_pkg::idx_t'(rie_pkg::TABLE_LEN - 1);
    found = 1'b0;
    for (int i = 0; i < rie_pkg::TABLE_LEN; i++) begin
      if (!found && (rest_r >= rie_pkg::WEIGHT[i])) begin
        sel   = rie_pkg::idx_t'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    emit         = 1'b0;
    emit_sym     = rie_pkg::NO_CH;
    emit_last    = 1'b0;
    emit_bad     = 1'b0;
    rest_nxt     = rest_r;
    pend_nxt     = pend_r;
    pend_sym_nxt = pend_sym_r;
    bad_nxt      = bad_r;
    active_nxt   = active_r;
    if (active_r) begin
      emit = 1'b1;
      priority if (bad_r) begin
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end else if (pend_r) begin
        // second letter of a subtractive pair
        emit_sym  = pend_sym_r;
        emit_last = (rest_r == '0);
        pend_nxt  = 1'b0;
      end else begin
        emit_sym     = rie_pkg::FIRST_CH[sel];
        rest_nxt     = rest_r - rie_pkg::WEIGHT[sel];
        pend_sym_nxt = rie_pkg::SECOND_CH[sel];
        pend_nxt     = (rie_pkg::SECOND_CH[sel] != rie_pkg::NO_CH);
        emit_last    = !pend_nxt && (rest_r == rie_pkg::WEIGHT[sel]);
      end
    end
    // next item is taken in while the last letter goes out
    load = q_valid && (!active_r || emit_last);
    if (load) begin
      active_nxt = 1'b1;
      bad_nxt    = q_entry.bad;
      rest_nxt   = q_entry.value;
      pend_nxt   = 1'b0;
    end else if (emit_last) begin
      active_nxt = 1'b0;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    bad_r      <= bad_nxt;
    rest_r     <= rest_nxt;
    pend_sym_r <= pend_sym_nxt;
    symbol_r   <= emit_sym;
    last_r     <= emit_last;
    bad_out_r  <= emit_bad;
  end

  assign out_strobe    = strobe_r;
  assign out_symbol    = symbol_r;
  assign out_last      = last_r;
  assign out_bad_value = bad_out_r;

  // an error item is a single result
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && bad_out_r |-> last_r && (symbol_r == rie_pkg::NO_CH))
    else $error("error result not a lone final result");

  // a pending second letter only exists inside an active item
  a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> active_r && !bad_r)
    else $error("pending letter outside an active numeral");

  // good letters are never the null code
  a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !bad_out_r |-> (symbol_r != rie_pkg::NO_CH))
    else $error("null letter in a valid numeral");

  // a pop always lands on a loaded engine
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> active_r && (pend_r == 1'b0))
    else $error("engine not loaded after pop");

endmodule

@@ rtl/integer_to_roman_encoder.sv @@
// top level of the integer to roman numeral encoder
//
// usage
// - input: drive in_value and raise start; the item is taken at a rising
//   edge where start is high and busy is low
// - busy is high while the item queue between front and back end is full
//   (QUEUE_DEPTH items waiting)
// - output: one ascii letter (I V X L C D M) per cycle on out_symbol, marked
//   by out_strobe for exactly one cycle; out_last flags the final letter
// - values 0 and above 3999 give one result with out_symbol 0, out_last 1
//   and out_bad_value 1
// - path: an accepted item is written to the queue, then loaded into the engine,
//   and each of its letters is registered before it is strobed
// - throughput: the back end emits one letter per cycle; a numeral has 1 to
//   15 letters, and an error item gives one result;
//   the next item is loaded while the last letter goes out, so numerals
//   follow each other with no gap when the next item is already queued
// - reset clears the queue and the engine; nothing is emitted afterward
//   until an item is taken
// - the receiver cannot stall: every strobed letter is taken at once
module integer_to_roman_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [11:0]          in_value,
  output logic                 out_strobe,
  output logic [6:0]           out_symbol,
  output logic                 out_last,
  output logic                 out_bad_value
);

  // queue handoff between front and back end
  logic            q_valid;
  logic            q_pop;
  rie_pkg::entry_t q_entry;

  // front end: range check and queue of classified items
  rie_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  // back end: greedy letter generator with registered outputs
  rie_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_symbol    (out_symbol),
    .out_last      (out_last),
    .out_bad_value (out_bad_value)
  );

endmodule

@@ test/tb_top.sv @@
// testbench of the integer to roman numeral encoder: directed and random values, letters checked
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one value waiting to be sent, with the idle cycles in front of it
  // and whether the sender first lets every pending letter come out
  typedef struct {
    rie_pkg::value_t value;
    int              gap;
    bit              drain;
  } send_item_t;

  // one expected letter on the result side
  typedef struct {
    rie_pkg::sym_t symbol;
    logic          last;
    logic          bad;
  } letter_t;

  // letters per decimal position, thousands first
  localparam rie_pkg::sym_t ONE_CH [4] = '{
    rie_pkg::CH_M, rie_pkg::CH_C, rie_pkg::CH_X, rie_pkg::CH_I
  };
  localparam rie_pkg::sym_t FIVE_CH [4] = '{
    rie_pkg::NO_CH, rie_pkg::CH_D, rie_pkg::CH_L, rie_pkg::CH_V
  };
  localparam rie_pkg::sym_t TEN_CH [4] = '{
    rie_pkg::NO_CH, rie_pkg::CH_M, rie_pkg::CH_C, rie_pkg::CH_X
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [11:0] in_value = '0;
  logic        busy;
  logic        out_strobe;
  logic [6:0]  out_symbol;
  logic        out_last;
  logic        out_bad_value;

  send_item_t send_q[$];    // values not yet offered
  send_item_t held;         // value popped, waiting out its gap
  bit         held_valid = 1'b0;
  int         idle_left = 0;
  letter_t    letters_due[$];

  int n_planned = 0;
  int n_bad_planned = 0;
  int n_taken = 0;
  int n_letters = 0;
  int n_errors = 0;

  integer_to_roman_encoder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .out_bad_value(out_bad_value)
  );

  always #2 clk = ~clk;

  function automatic void push_letter(rie_pkg::sym_t s);
    letter_t l;
    l.symbol = s;
    l.last = 1'b0;
    l.bad = 1'b0;
    letters_due.push_back(l);
  endfunction

  // expected letters of one value, built digit by digit rather than by
  // greedy subtraction; both give the same numeral
  function automatic void predict_numeral(rie_pkg::value_t v);
    letter_t l;
    int rest;
    int base;
    int d;
    // zero and anything past 3999 give a single flagged result
    if (v == 0 || v > rie_pkg::MAX_VALID) begin
      l.symbol = rie_pkg::NO_CH;
      l.last = 1'b1;
      l.bad = 1'b1;
      letters_due.push_back(l);
      return;
    end
    rest = v;
    base = 1000;
    for (int pos = 0; pos < 4; pos++) begin
      d = rest / base;
      rest = rest % base;
      base = base / 10;
      case (d)
        4: begin
          push_letter(ONE_CH[pos]);
          push_letter(FIVE_CH[pos]);
        end
        9: begin
          push_letter(ONE_CH[pos]);
          push_letter(TEN_CH[pos]);
        end
        default: begin
          if (d >= 5) push_letter(FIVE_CH[pos]);
          repeat (d % 5) push_letter(ONE_CH[pos]);
        end
      endcase
    end
    letters_due[letters_due.size()-1].last = 1'b1;
  endfunction

  function automatic void plan_item(int v, int gap, bit drain);
    send_item_t s;
    s.value = v[11:0];
    s.gap = gap;
    s.drain = drain;
    send_q.push_back(s);
    n_planned++;
    if (v == 0 || v > 3999) n_bad_planned++;
  endfunction

  // mostly valid values, with long numerals weighted up and some
  // out of range ones mixed in
  function automatic int random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom_range(4095, 4000);
    if (pick < 10) return 0;
    if (pick < 30) begin
      // every digit 3 or 8 (or a random thousands digit): long runs of letters
      return $urandom_range(3) * 1000 + ($urandom_range(1) ? 800 : 300)
        + ($urandom_range(1) ? 80 : 30) + ($urandom_range(1) ? 8 : 3);
    end
    if (pick < 45) return $urandom_range(49, 1);
    return $urandom_range(3999, 1);
  endfunction

  function automatic int random_gap();
    return ($urandom_range(3) == 0) ? $urandom_range(14, 1) : 0;
  endfunction

  // sender: an item is taken on an edge with start high and busy low;
  // start and in_value are held until then, and get one assignment per edge
  always @(posedge clk) begin
    logic go;
    if (rst_n) begin
      if (start && !busy) begin
        predict_numeral(in_value);
        n_taken++;
      end
      // still offering the same item if it was not taken
      go = start && busy;
      if (!go) begin
        if (!held_valid && send_q.size() > 0) begin
          held = send_q.pop_front();
          held_valid = 1'b1;
          idle_left = held.gap;
        end
        if (held_valid) begin
          if (idle_left > 0) begin
            idle_left--;
          end else if (!(held.drain && letters_due.size() > 0)) begin
            // a drain item is held back until the output side has gone quiet
            go = 1'b1;
            in_value <= held.value;
            held_valid = 1'b0;
          end
        end
      end
      start <= go;
    end
  end

  // receiver: letters cannot be stalled, so each strobe is checked at once
  // against the oldest expected letter
  always @(posedge clk) begin
    letter_t want;
    if (rst_n && out_strobe) begin
      if (letters_due.size() == 0) begin
        n_errors++;
        $error("unexpected letter: out_symbol %0h out_last %0b out_bad_value %0b",
               out_symbol, out_last, out_bad_value);
      end else begin
        want = letters_due.pop_front();
        n_letters++;
        if (out_symbol !== want.symbol) begin
          n_errors++;
          $error("out_symbol: expected %0h, got %0h", want.symbol, out_symbol);
        end
        if (out_last !== want.last) begin
          n_errors++;
          $error("out_last: expected %0b, got %0b", want.last, out_last);
        end
        if (out_bad_value !== want.bad) begin
          n_errors++;
          $error("out_bad_value: expected %0b, got %0b", want.bad, out_bad_value);
        end
      end
    end
  end

  initial begin
    // directed values: both ends of the range, out of range on both sides,
    // every subtractive pair, the longest numeral, a single bit and alternating bit patterns
    int dir_vals [22] = '{0, 1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 900, 999,
                          1994, 3888, 3999, 4000, 4095, 2048, 1365, 2730};
    for (int i = 0; i < 22; i++) begin
      // first items back to back to fill the queue; one drain in the middle
      plan_item(dir_vals[i], 0, i == 11);
    end
    // random part; the last stretch runs with no idling at all
    for (int i = 0; i < 380; i++) begin
      plan_item(random_value(), (i < 320) ? random_gap() : 0, i == 150 || i == 260);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_planned) @(posedge clk);
    while (letters_due.size() != 0) @(posedge clk);
    // wait on to catch any letter that should not be there
    repeat (20) @(posedge clk);

    $display("sent %0d values (%0d out of range), compared %0d letters",
             n_planned, n_bad_planned, n_letters);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #1_000_000;
    $display("timeout: %0d of %0d values taken, %0d letters pending",
             n_taken, n_planned, letters_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
